// ----- hw/rtl/led_pkg.sv -----
`timescale 1ns / 1ps

package led_pkg;

   localparam int KeyWidth       = 8;
   localparam int ActionWidth    = 3;
   localparam int CountWidth     = 6;
   localparam int RspFieldsWidth = ActionWidth + CountWidth + KeyWidth;
   localparam int RspDataWidth   = ((RspFieldsWidth + 7) / 8) * 8;
   localparam int CsrIndexWidth  = 8;
   localparam int LineWidthDef   = 40;

   localparam logic [KeyWidth-1:0] CodeEof    = 8'd4;
   localparam logic [KeyWidth-1:0] CodeWerase = 8'd23;
   localparam logic [KeyWidth-1:0] CodeNl     = 8'd10;
   localparam logic [KeyWidth-1:0] CodeSpace  = 8'd32;
   localparam logic [KeyWidth-1:0] PrintLow   = 8'h20;
   localparam logic [KeyWidth-1:0] PrintHigh  = 8'h7e;

   localparam logic [KeyWidth-1:0] EraseReset = 8'd127;
   localparam logic [KeyWidth-1:0] KillReset  = 8'd21;

   localparam logic [CsrIndexWidth-1:0] RegErase = 8'd0;
   localparam logic [CsrIndexWidth-1:0] RegKill  = 8'd1;

   typedef enum logic [ActionWidth-1:0] {
      ACT_ECHO    = 3'd0,
      ACT_ERASE   = 3'd1,
      ACT_NEWLINE = 3'd2,
      ACT_BELL    = 3'd3,
      ACT_END     = 3'd4
   } action_type;

endpackage

// ----- hw/rtl/line_editor_with_word_wrap.sv -----
// Line editor with word wrap: one keystroke byte per req beat, zero or more display
// actions per key on rsp, tlast marking the final one. Keys are accepted only while
// the sequencer is idle. A word erase scans back through the line memory. A printable
// key at full width scans back for the start of the trailing word; if one is found it
// emits an erase and a newline and copies the word to the start of the new line, else
// only a newline, then it echoes the key. The scan and the copy both walk the single
// read port of the line memory, one entry at a time. After an end-of-input on an empty
// line every key is taken and dropped until reset.
`timescale 1ns / 1ps

module line_editor_with_word_wrap
   import led_pkg::*;
#(
   parameter int LINE_WIDTH = LineWidthDef
) (
   input  logic                     clock,
   input  logic                     reset,
   // key_byte
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [KeyWidth-1:0]      req_tdata,
   // action[2:0], erase_count[8:3], echo_char[16:9], zero fill above
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,
   output logic                     rsp_tlast,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [KeyWidth-1:0]      csr_data
);

   localparam int CW = $clog2(LINE_WIDTH + 1);
   localparam int AW = $clog2(LINE_WIDTH);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ONE,
      S_WSP,
      S_WWD,
      S_WRS,
      S_WERA,
      S_WNL,
      S_COPY,
      S_KEY
   } state_type;

   state_type             state_ff;
   logic                  closed_ff;
   logic [CW-1:0]         cursor_ff;
   logic [CW-1:0]         p_ff;
   logic [CW-1:0]         src_ff;
   logic [CW-1:0]         cp_ff;
   logic                  word_ff;
   logic [KeyWidth-1:0]   key_ff;
   action_type            pend_act_ff;
   logic [CW-1:0]         pend_cnt_ff;
   logic [KeyWidth-1:0]   erase_ff;
   logic [KeyWidth-1:0]   kill_ff;

   logic                  rsp_valid_ff;
   action_type            rsp_act_ff;
   logic [CountWidth-1:0] rsp_cnt_ff;
   logic [KeyWidth-1:0]   rsp_char_ff;
   logic                  rsp_last_ff;

   logic [KeyWidth-1:0]   mem [LINE_WIDTH];
   logic [KeyWidth-1:0]   rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   logic [KeyWidth-1:0]   mem_wd;

   logic                  slot_free;
   logic                  emit_en;
   action_type            emit_act;
   logic [CW-1:0]         emit_cnt;
   logic [KeyWidth-1:0]   emit_char;
   logic                  emit_last;
   logic                  req_beat;
   logic                  is_space;

   function automatic logic [AW-1:0] idx_of(input logic [CW:0] v);
      logic [AW-1:0] r;
      r = '0;
      if (v < (CW + 1)'(LINE_WIDTH)) begin
         r = v[AW-1:0];
      end
      return r;
   endfunction

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign is_space   = (rd_data_ff == CodeSpace);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RspDataWidth'({rsp_char_ff, rsp_cnt_ff, rsp_act_ff});

   // result for the current state
   always_comb begin
      emit_en   = 1'b0;
      emit_act  = ACT_ECHO;
      emit_cnt  = '0;
      emit_char = '0;
      emit_last = 1'b0;
      case (state_ff)
         S_ONE: begin
            emit_en   = slot_free;
            emit_act  = pend_act_ff;
            emit_cnt  = pend_cnt_ff;
            emit_last = 1'b1;
         end
         S_WERA: begin
            emit_en  = slot_free;
            emit_act = ACT_ERASE;
            emit_cnt = pend_cnt_ff;
         end
         S_WNL: begin
            emit_en  = slot_free;
            emit_act = ACT_NEWLINE;
         end
         S_COPY: begin
            emit_en   = slot_free;
            emit_act  = ACT_ECHO;
            emit_char = rd_data_ff;
         end
         S_KEY: begin
            emit_en   = slot_free;
            emit_act  = ACT_ECHO;
            emit_char = key_ff;
            emit_last = 1'b1;
         end
         default: begin
            emit_en = 1'b0;
         end
      endcase
   end

   // line memory access
   always_comb begin
      case (state_ff)
         S_WSP, S_WWD, S_WRS: rd_addr = idx_of({1'b0, p_ff} - (CW + 1)'(2));
         S_WNL:               rd_addr = idx_of({1'b0, p_ff});
         S_COPY: begin
            if (slot_free) begin
               rd_addr = idx_of({1'b0, src_ff} + (CW + 1)'(1));
            end else begin
               rd_addr = idx_of({1'b0, src_ff});
            end
         end
         default:             rd_addr = idx_of({1'b0, cursor_ff} - (CW + 1)'(1));
      endcase
      mem_we = emit_en && ((state_ff == S_COPY) || (state_ff == S_KEY));
      if (state_ff == S_COPY) begin
         mem_wa = idx_of({1'b0, cp_ff});
         mem_wd = rd_data_ff;
      end else begin
         mem_wa = idx_of({1'b0, cursor_ff});
         mem_wd = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         closed_ff    <= 1'b0;
         cursor_ff    <= '0;
         p_ff         <= '0;
         src_ff       <= '0;
         cp_ff        <= '0;
         word_ff      <= 1'b0;
         pend_act_ff  <= ACT_ECHO;
         pend_cnt_ff  <= '0;
         erase_ff     <= EraseReset;
         kill_ff      <= KillReset;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == RegErase) begin
               erase_ff <= csr_data;
            end else if (csr_index == RegKill) begin
               kill_ff <= csr_data;
            end
         end

         if (emit_en) begin
            rsp_valid_ff <= 1'b1;
            rsp_act_ff   <= emit_act;
            rsp_cnt_ff   <= CountWidth'(emit_cnt);
            rsp_char_ff  <= emit_char;
            rsp_last_ff  <= emit_last;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_beat && !closed_ff) begin
                  key_ff <= req_tdata;
                  p_ff   <= cursor_ff;
                  if (req_tdata == CodeEof && cursor_ff == '0) begin
                     closed_ff   <= 1'b1;
                     pend_act_ff <= ACT_END;
                     pend_cnt_ff <= '0;
                     state_ff    <= S_ONE;
                  end else if (req_tdata == erase_ff) begin
                     if (cursor_ff != '0) begin
                        cursor_ff   <= cursor_ff - CW'(1);
                        pend_act_ff <= ACT_ERASE;
                        pend_cnt_ff <= CW'(1);
                        state_ff    <= S_ONE;
                     end
                  end else if (req_tdata == kill_ff) begin
                     if (cursor_ff != '0) begin
                        cursor_ff   <= '0;
                        pend_act_ff <= ACT_ERASE;
                        pend_cnt_ff <= cursor_ff;
                        state_ff    <= S_ONE;
                     end
                  end else if (req_tdata == CodeWerase) begin
                     state_ff <= S_WSP;
                  end else if (req_tdata == CodeNl) begin
                     cursor_ff   <= '0;
                     pend_act_ff <= ACT_NEWLINE;
                     pend_cnt_ff <= '0;
                     state_ff    <= S_ONE;
                  end else if (req_tdata >= PrintLow && req_tdata <= PrintHigh) begin
                     if (cursor_ff == CW'(LINE_WIDTH)) begin
                        state_ff <= S_WRS;
                     end else begin
                        state_ff <= S_KEY;
                     end
                  end else begin
                     pend_act_ff <= ACT_BELL;
                     pend_cnt_ff <= '0;
                     state_ff    <= S_ONE;
                  end
               end
            end
            S_ONE: begin
               if (emit_en) begin
                  state_ff <= S_IDLE;
               end
            end
            // trailing spaces
            S_WSP: begin
               if (p_ff == '0) begin
                  state_ff <= S_WWD;
               end else begin
                  p_ff <= p_ff - CW'(1);
                  if (!is_space) begin
                     state_ff <= S_WWD;
                  end
               end
            end
            // word before them
            S_WWD: begin
               if (p_ff == '0 || is_space) begin
                  if (p_ff < cursor_ff) begin
                     pend_act_ff <= ACT_ERASE;
                     pend_cnt_ff <= cursor_ff - p_ff;
                     cursor_ff   <= p_ff;
                     state_ff    <= S_ONE;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  p_ff <= p_ff - CW'(1);
               end
            end
            // find start of the trailing word at full width
            S_WRS: begin
               if (p_ff == '0 || is_space) begin
                  word_ff     <= (p_ff != '0) && (p_ff != cursor_ff);
                  pend_cnt_ff <= cursor_ff - p_ff;
                  if ((p_ff != '0) && (p_ff != cursor_ff)) begin
                     state_ff <= S_WERA;
                  end else begin
                     state_ff <= S_WNL;
                  end
               end else begin
                  p_ff <= p_ff - CW'(1);
               end
            end
            S_WERA: begin
               if (emit_en) begin
                  state_ff <= S_WNL;
               end
            end
            S_WNL: begin
               if (emit_en) begin
                  src_ff <= p_ff;
                  cp_ff  <= '0;
                  if (word_ff) begin
                     cursor_ff <= pend_cnt_ff;
                     state_ff  <= S_COPY;
                  end else begin
                     cursor_ff <= '0;
                     state_ff  <= S_KEY;
                  end
               end
            end
            S_COPY: begin
               if (emit_en) begin
                  src_ff <= src_ff + CW'(1);
                  cp_ff  <= cp_ff + CW'(1);
                  if (cp_ff == cursor_ff - CW'(1)) begin
                     state_ff <= S_KEY;
                  end
               end
            end
            S_KEY: begin
               if (emit_en) begin
                  cursor_ff <= cursor_ff + CW'(1);
                  state_ff  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= CW'(LINE_WIDTH))
      else $error("cursor beyond line width");

   a_closed_quiet: assert property (@(posedge clock) disable iff (reset)
      closed_ff && state_ff == S_IDLE |=> state_ff == S_IDLE && !emit_en)
      else $error("closed editor produced work");

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      mem_we && state_ff == S_KEY |-> cursor_ff < CW'(LINE_WIDTH))
      else $error("key stored at full width");

   a_copy_order: assert property (@(posedge clock) disable iff (reset)
      mem_we && state_ff == S_COPY |-> cp_ff < src_ff)
      else $error("copy destination not below source");

endmodule

// ----- verif/line_editor_with_word_wrap_tb.sv -----
`timescale 1ns / 1ps

module line_editor_with_word_wrap_tb;
   import led_pkg::*;

   localparam int Cols         = LineWidthDef;
   localparam int SettleCycles = 120;
   localparam int HoldCycles   = 300;
   localparam int WatchLimit   = 4000;

   localparam logic [CsrIndexWidth-1:0] RegSpare = 8'd2;
   localparam logic [CsrIndexWidth-1:0] RegTop   = 8'hff;
   localparam logic [KeyWidth-1:0]      KeyEsc   = 8'h1b;
   localparam logic [KeyWidth-1:0]      KeyBel   = 8'h07;

   typedef struct {
      action_type              act;
      logic [CountWidth-1:0]   cnt;
      logic [KeyWidth-1:0]     ch;
      logic                    last;
   } display_action_type;

   class echo_scoreboard_type;
      logic [KeyWidth-1:0] erase_code;
      logic [KeyWidth-1:0] kill_code;
      logic [KeyWidth-1:0] line_buf [Cols];
      int                  cursor;
      bit                  closed;
      display_action_type  pending_actions [$];
      int                  keys_noted;
      int                  actions_seen;
      int                  word_moves;
      int                  margin_breaks;
      int                  mismatches;

      function new();
         erase_code    = EraseReset;
         kill_code     = KillReset;
         cursor        = 0;
         closed        = 1'b0;
         keys_noted    = 0;
         actions_seen  = 0;
         word_moves    = 0;
         margin_breaks = 0;
         mismatches    = 0;
      endfunction

      function void set_reg(logic [CsrIndexWidth-1:0] idx, logic [KeyWidth-1:0] val);
         if (idx == RegErase) begin
            erase_code = val;
         end else if (idx == RegKill) begin
            kill_code = val;
         end
      endfunction

      function void add_action(action_type a, int cnt, logic [KeyWidth-1:0] ch);
         display_action_type d;
         d.act  = a;
         d.cnt  = cnt[CountWidth-1:0];
         d.ch   = ch;
         d.last = 1'b0;
         pending_actions.push_back(d);
      endfunction

      function void note_key(logic [KeyWidth-1:0] key);
         int                 first;
         int                 p;
         int                 n;
         display_action_type tail;
         if (closed) begin
            return;
         end
         keys_noted++;
         first = pending_actions.size();
         if (key == CodeEof && cursor == 0) begin
            closed = 1'b1;
            add_action(ACT_END, 0, 8'h00);
         end else if (key == erase_code) begin
            if (cursor > 0) begin
               cursor--;
               add_action(ACT_ERASE, 1, 8'h00);
            end
         end else if (key == kill_code) begin
            if (cursor > 0) begin
               add_action(ACT_ERASE, cursor, 8'h00);
               cursor = 0;
            end
         end else if (key == CodeWerase) begin
            p = cursor;
            while (p > 0 && line_buf[p-1] == CodeSpace) p--;
            while (p > 0 && line_buf[p-1] != CodeSpace) p--;
            if (p < cursor) begin
               add_action(ACT_ERASE, cursor - p, 8'h00);
               cursor = p;
            end
         end else if (key == CodeNl) begin
            cursor = 0;
            add_action(ACT_NEWLINE, 0, 8'h00);
         end else if (key >= PrintLow && key <= PrintHigh) begin
            if (cursor >= Cols) begin
               p = cursor;
               while (p > 0 && line_buf[p-1] != CodeSpace) p--;
               if (p > 0 && cursor > p) begin
                  // carry the trailing word onto a fresh line
                  n = cursor - p;
                  add_action(ACT_ERASE, n, 8'h00);
                  add_action(ACT_NEWLINE, 0, 8'h00);
                  for (int i = 0; i < n; i++) begin
                     line_buf[i] = line_buf[p+i];
                     add_action(ACT_ECHO, 0, line_buf[i]);
                  end
                  cursor = n;
                  word_moves++;
               end else begin
                  add_action(ACT_NEWLINE, 0, 8'h00);
                  cursor = 0;
                  margin_breaks++;
               end
            end
            if (cursor < Cols) begin
               line_buf[cursor] = key;
               cursor++;
            end
            add_action(ACT_ECHO, 0, key);
         end else begin
            add_action(ACT_BELL, 0, 8'h00);
         end
         if (pending_actions.size() > first) begin
            tail = pending_actions.pop_back();
            tail.last = 1'b1;
            pending_actions.push_back(tail);
         end
      endfunction

      function void check_result(logic [RspDataWidth-1:0] data, logic last_bit);
         display_action_type                      want;
         logic [ActionWidth-1:0]                  got_act;
         logic [CountWidth-1:0]                   got_cnt;
         logic [KeyWidth-1:0]                     got_ch;
         logic [RspDataWidth-RspFieldsWidth-1:0]  got_fill;
         got_act  = data[ActionWidth-1:0];
         got_cnt  = data[ActionWidth +: CountWidth];
         got_ch   = data[ActionWidth+CountWidth +: KeyWidth];
         got_fill = data[RspDataWidth-1:RspFieldsWidth];
         actions_seen++;
         if (pending_actions.size() == 0) begin
            $error("unexpected beat: tdata %h tlast %b", data, last_bit);
            mismatches++;
            return;
         end
         want = pending_actions.pop_front();
         if (got_act !== want.act) begin
            $error("action: expected %0d, got %0d", want.act, got_act);
            mismatches++;
         end
         if (got_cnt !== want.cnt) begin
            $error("erase_count: expected %0d, got %0d", want.cnt, got_cnt);
            mismatches++;
         end
         if (got_ch !== want.ch) begin
            $error("echo_char: expected %h, got %h", want.ch, got_ch);
            mismatches++;
         end
         if (last_bit !== want.last) begin
            $error("last: expected %b, got %b", want.last, last_bit);
            mismatches++;
         end
         if (got_fill !== '0) begin
            $error("tdata fill: expected 0, got %h", got_fill);
            mismatches++;
         end
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [KeyWidth-1:0]       req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]   rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CsrIndexWidth-1:0]  csr_index  = '0;
   logic [KeyWidth-1:0]       csr_data   = '0;
   logic                      hold_go    = 1'b0;

   echo_scoreboard_type sb;
   int  send_idle  = 0;
   int  recv_idle  = 0;
   int  word_left  = 0;
   int  hold_left  = 0;
   int  quiet      = 0;
   bit  hold_taken = 1'b0;
   bit  closing    = 1'b0;

   line_editor_with_word_wrap #(.LINE_WIDTH(Cols)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // result side: check each beat, then pick ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tlast);
         end
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
      end
      if (quiet >= WatchLimit) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic send_key(input logic [KeyWidth-1:0] key_in);
      logic [KeyWidth-1:0] key;
      key = key_in;
      // keep the session open until the closing sequence
      if (!closing && key == CodeEof && sb.cursor == 0) key = KeyEsc;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= key;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_key(key);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [KeyWidth-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending_actions.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [KeyWidth-1:0] glyph();
      return KeyWidth'($urandom_range(8'h21, 8'h7e));
   endfunction

   function automatic logic [KeyWidth-1:0] word_char();
      if (word_left == 0) begin
         word_left = $urandom_range(0, 11);
         return CodeSpace;
      end
      word_left--;
      return glyph();
   endfunction

   function automatic logic [KeyWidth-1:0] line_char();
      int r;
      r = $urandom_range(99);
      if (r < 3) return sb.erase_code;
      if (r < 5) return CodeWerase;
      if (r == 5) return sb.kill_code;
      if (r == 6) return CodeEof;
      return word_char();
   endfunction

   task automatic type_line(input int len);
      repeat (len) send_key(line_char());
   endtask

   task automatic long_word();
      repeat ($urandom_range(45, 55)) send_key(glyph());
   endtask

   // fill to the margin with a space in the last column, then one more glyph
   task automatic space_at_edge();
      while (sb.cursor < Cols) begin
         send_key(sb.cursor == Cols - 1 ? CodeSpace : word_char());
      end
      send_key(glyph());
   endtask

   task automatic noise();
      int r;
      repeat ($urandom_range(1, 6)) begin
         r = $urandom_range(5);
         case (r)
            0: send_key(sb.erase_code);
            1: send_key(sb.kill_code);
            2: send_key(CodeWerase);
            3: send_key(CodeNl);
            4: send_key(KeyWidth'($urandom_range(0, 8'h1f)));
            default: send_key(KeyWidth'($urandom_range(0, 8'hff)));
         endcase
      end
   endtask

   task automatic run_phase(input int quota);
      int start;
      int r;
      start = sb.keys_noted;
      while (sb.keys_noted - start < quota) begin
         r = $urandom_range(99);
         if (r < 55) type_line($urandom_range(20, 60));
         else if (r < 65) long_word();
         else if (r < 72) space_at_edge();
         else noise();
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_reg(RegErase, EraseReset);
      write_reg(RegKill, KillReset);
      write_reg(RegSpare, 8'haa);

      send_idle = 33;
      recv_idle = 71;
      send_key(8'h00);
      send_key(EraseReset);
      send_key(KillReset);
      send_key(CodeWerase);
      send_key(8'hff);
      send_key("a");
      send_key("b");
      send_key(CodeSpace);
      send_key("c");
      send_key("d");
      send_key(CodeSpace);
      send_key(CodeSpace);
      send_key(CodeWerase);
      send_key(CodeEof);
      send_key(CodeWerase);
      send_key(PrintHigh);
      send_key(PrintLow);
      send_key(EraseReset);
      send_key(KillReset);
      send_key(CodeNl);
      send_key(8'h80);
      send_key(KeyBel);
      long_word();
      space_at_edge();
      run_phase(10);
      settle();

      write_reg(RegErase, 8'h00);
      write_reg(RegKill, 8'hff);
      write_reg(RegTop, 8'h55);
      send_idle = 71;
      recv_idle = 33;
      run_phase(20);
      settle();

      // werase byte now erases one column, end-of-input now kills a line
      write_reg(RegErase, CodeWerase);
      write_reg(RegKill, CodeEof);
      send_idle = 0;
      recv_idle = 0;
      hold_go <= 1'b1;
      type_line(20);
      run_phase(10);

      send_key(CodeNl);
      closing = 1'b1;
      send_key(CodeEof);
      send_key("a");
      send_key(CodeNl);
      send_key(8'h00);
      settle();

      $display("run covered %0d keys and %0d display beats", sb.keys_noted, sb.actions_seen);
      $display("wrap: %0d word moves, %0d bare margin breaks", sb.word_moves,
               sb.margin_breaks);
      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
